@@ hw/rtl/pebs_pkg.sv @@
// Shared constants, types and helpers for the percent encoder with bitmap character set.
package pebs_pkg;

    // Bytes handled side by side in one request (1 to 8).
    localparam int LANES      = 8;
    localparam int IN_CNT_W   = 4;
    localparam int OUT_BYTES  = 24;
    localparam int OUT_CNT_W  = 5;
    localparam int WORD_BYTES = 8;

    // APB register file: four 64-bit words at byte addresses 8*i.
    localparam int NUM_REGS    = 4;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);
    localparam int REG_IDX_LSB = 3;
    localparam int ADDR_W      = REG_IDX_LSB + REG_IDX_W;
    localparam int DATA_W      = 64;
    localparam int BITMAP_W    = NUM_REGS * DATA_W;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_SET_BITS_0 = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_SET_BITS_1 = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_SET_BITS_2 = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_SET_BITS_3 = REG_IDX_W'(3);

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_A       = 8'h41;

    // Group lengths a lane can produce.
    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_PLAIN = 2'd1;
    localparam logic [1:0] LEN_ESC   = 2'd3;

    // What one lane hands to the merge stage.
    typedef struct packed {
        logic [2:0][7:0] grp;
        logic [1:0]      len;
    } lane_t;

    // One finished result.
    typedef struct packed {
        logic [OUT_BYTES-1:0][7:0] bytes;
        logic [OUT_CNT_W-1:0]      count;
        logic                      last;
    } result_t;

    // Uppercase hex digit of one nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10)
            d = CHAR_ZERO + {4'd0, nib};
        else
            d = CHAR_A + {4'd0, nib} - 8'd10;
        return d;
    endfunction

endpackage

@@ hw/rtl/pebs_cfg.sv @@
// APB register file holding the 256-bit character-set bitmap.
module pebs_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pebs_pkg::ADDR_W-1:0]  paddr,
    input  logic [pebs_pkg::DATA_W-1:0]  pwdata,
    output logic [pebs_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [pebs_pkg::BITMAP_W-1:0] bitmap
);

    logic [pebs_pkg::NUM_REGS-1:0][pebs_pkg::DATA_W-1:0] set_bits_reg;
    logic [pebs_pkg::REG_IDX_W-1:0]                      idx;

    assign idx    = paddr[pebs_pkg::ADDR_W-1:pebs_pkg::REG_IDX_LSB];
    assign pready = 1'b1;
    assign prdata = set_bits_reg[idx];
    assign bitmap = set_bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            set_bits_reg[idx] <= pwdata;
        end
    end

endmodule

@@ hw/rtl/pebs_lane.sv @@
// One encoding lane: classify a byte and register its one- or three-byte group, or an empty group when inactive.
module pebs_lane (
    input  logic                          clk,
    input  logic [7:0]                    in_byte,
    input  logic                          active,
    input  logic [pebs_pkg::BITMAP_W-1:0] bitmap,
    output pebs_pkg::lane_t               lane_q
);

    pebs_pkg::lane_t lane_reg;
    pebs_pkg::lane_t lane_next;

    always_comb
    begin
        lane_next = '0;
        if (active)
        begin
            if (bitmap[in_byte])
            begin
                lane_next.grp[0] = pebs_pkg::CHAR_PERCENT;
                lane_next.grp[1] = pebs_pkg::hex_digit(in_byte[7:4]);
                lane_next.grp[2] = pebs_pkg::hex_digit(in_byte[3:0]);
                lane_next.len    = pebs_pkg::LEN_ESC;
            end
            else
            begin
                lane_next.grp[0] = in_byte;
                lane_next.len    = pebs_pkg::LEN_PLAIN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign lane_q = lane_reg;

endmodule

@@ hw/rtl/pebs_merge.sv @@
// Merge stage: pack the lane groups in order and register the result.
module pebs_merge (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_last,
    input  pebs_pkg::lane_t [pebs_pkg::LANES-1:0] lanes,
    output logic                                  res_valid,
    output pebs_pkg::result_t                     res
);

    logic [pebs_pkg::LANES:0][pebs_pkg::OUT_CNT_W-1:0] off;
    pebs_pkg::result_t res_reg;
    pebs_pkg::result_t res_next;
    logic              valid_reg;

    always_comb
    begin
        off[0]   = '0;
        res_next = '0;
        for (int k = 0; k < pebs_pkg::LANES; k++)
        begin
            off[k+1] = off[k] + pebs_pkg::OUT_CNT_W'(lanes[k].len);
        end
        for (int k = 0; k < pebs_pkg::LANES; k++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                if (2'(b) < lanes[k].len)
                    res_next.bytes[off[k] + pebs_pkg::OUT_CNT_W'(b)] = lanes[k].grp[b];
            end
        end
        res_next.count = off[pebs_pkg::LANES];
        res_next.last  = in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

@@ hw/rtl/percent_encoder_bitmap_set.sv @@
// Top level of the percent encoder with a configurable 256-bit character set.
//
//  Channel   Handshake                          Payload
//  --------  ---------------------------------  ---------------------------------------
//  request   start (taken when busy is low)     in_bytes, in_count, in_last
//  result    done (one-cycle strobe)            out_bytes_low/mid/high, out_count, out_last
//  config    APB psel/penable/pwrite, pready=1  paddr, pwdata, prdata (64-bit words)
//
//  One request per cycle, back to back; busy never rises.
//  Each byte is classified and expanded in the lane registers, then the
//  merge register packs the groups by a running offset over the eight lanes.
//  Reset clears the bitmap words and the pipeline valid bits.
//  The receiver cannot stall: each result shows for exactly one cycle with done.
module percent_encoder_bitmap_set (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request
    input  logic                                 start,
    output logic                                 busy,
    input  logic [63:0]                          in_bytes,
    input  logic [pebs_pkg::IN_CNT_W-1:0]        in_count,
    input  logic                                 in_last,
    // result
    output logic                                 done,
    output logic [63:0]                          out_bytes_low,
    output logic [63:0]                          out_bytes_mid,
    output logic [63:0]                          out_bytes_high,
    output logic [pebs_pkg::OUT_CNT_W-1:0]       out_count,
    output logic                                 out_last,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pebs_pkg::ADDR_W-1:0]          paddr,
    input  logic [pebs_pkg::DATA_W-1:0]          pwdata,
    output logic [pebs_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    logic [pebs_pkg::BITMAP_W-1:0]         bitmap;
    logic [pebs_pkg::IN_CNT_W-1:0]         n_sat;
    logic                                  accept;
    pebs_pkg::lane_t [pebs_pkg::LANES-1:0] lane_q;
    logic                                  s1_valid_reg;
    logic                                  s1_last_reg;
    logic                                  res_valid;
    pebs_pkg::result_t                     res;

    // The pipeline never holds a request back.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Clamp the byte count to the lane count; bytes beyond it are dropped.
    assign n_sat = (in_count > pebs_pkg::IN_CNT_W'(pebs_pkg::LANES))
                 ? pebs_pkg::IN_CNT_W'(pebs_pkg::LANES) : in_count;

    pebs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .bitmap  (bitmap)
    );

    // One lane per input byte position.
    for (genvar k = 0; k < pebs_pkg::LANES; k++)
    begin : g_lane
        pebs_lane u_lane (
            .clk     (clk),
            .in_byte (in_bytes[8*k +: 8]),
            .active  (pebs_pkg::IN_CNT_W'(k) < n_sat),
            .bitmap  (bitmap),
            .lane_q  (lane_q[k])
        );
    end

    // Advance the request's valid and end-of-string flag alongside the lanes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg <= in_last;
    end

    pebs_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_last   (s1_last_reg),
        .lanes     (lane_q),
        .res_valid (res_valid),
        .res       (res)
    );

    // Split the packed 24-byte buffer into the three output words.
    assign done           = res_valid;
    assign out_bytes_low  = res.bytes[pebs_pkg::WORD_BYTES-1:0];
    assign out_bytes_mid  = res.bytes[2*pebs_pkg::WORD_BYTES-1:pebs_pkg::WORD_BYTES];
    assign out_bytes_high = res.bytes[3*pebs_pkg::WORD_BYTES-1:2*pebs_pkg::WORD_BYTES];
    assign out_count      = res.count;
    assign out_last       = res.last;

endmodule

@@ verif/percent_escape_checker.sv @@
// Checker for the percent encoder: predicts each escaped result from observed requests and APB writes.
module percent_escape_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [63:0]                     in_bytes,
    input  logic [pebs_pkg::IN_CNT_W-1:0]   in_count,
    input  logic                            in_last,
    input  logic                            done,
    input  logic [63:0]                     out_bytes_low,
    input  logic [63:0]                     out_bytes_mid,
    input  logic [63:0]                     out_bytes_high,
    input  logic [pebs_pkg::OUT_CNT_W-1:0]  out_count,
    input  logic                            out_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [pebs_pkg::ADDR_W-1:0]     paddr,
    input  logic [pebs_pkg::DATA_W-1:0]     pwdata,
    output int                              mismatch_count,
    output int                              outstanding
);
    import pebs_pkg::*;

    localparam logic [7:0] ASCII_PERCENT     = 8'h25;
    localparam logic [7:0] ASCII_ZERO        = 8'h30;
    localparam logic [7:0] ASCII_LETTER_BASE = 8'h37;   // 'A' minus ten

    typedef struct packed {
        logic [63:0]          low;
        logic [63:0]          mid;
        logic [63:0]          high;
        logic [OUT_CNT_W-1:0] count;
        logic                 last;
    } escaped_t;

    logic [255:0] charset;
    escaped_t     pending_escapes[$];

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? ASCII_ZERO + 8'(nib) : ASCII_LETTER_BASE + 8'(nib);
    endfunction

    // Expand marked bytes to %HH and pack everything in input order.
    function automatic escaped_t escape_chunk(input logic [63:0] src,
                                              input logic [IN_CNT_W-1:0] cnt,
                                              input logic lst);
        escaped_t                  r;
        logic [OUT_BYTES-1:0][7:0] packed_out;
        logic [7:0]                ch;
        int                        n;
        int                        len;
        packed_out = '0;
        len = 0;
        n = (int'(cnt) > LANES) ? LANES : int'(cnt);
        for (int k = 0; k < n; k++)
        begin
            ch = src[8*k +: 8];
            if (charset[ch])
            begin
                packed_out[len]     = ASCII_PERCENT;
                packed_out[len + 1] = hex_char(ch[7:4]);
                packed_out[len + 2] = hex_char(ch[3:0]);
                len += 3;
            end
            else
            begin
                packed_out[len] = ch;
                len += 1;
            end
        end
        r.low   = packed_out[7:0];
        r.mid   = packed_out[15:8];
        r.high  = packed_out[23:16];
        r.count = OUT_CNT_W'(len);
        r.last  = lst;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $error("%s mismatch: expected %h, got %h", name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        escaped_t want;
        if (!rst_n)
        begin
            pending_escapes.delete();
            charset = '0;
            mismatch_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_escapes.size() == 0)
                begin
                    mismatch_count++;
                    $error("result with no request outstanding: out_count %0d", out_count);
                end
                else
                begin
                    want = pending_escapes.pop_front();
                    check_field("out_bytes_low", want.low, out_bytes_low);
                    check_field("out_bytes_mid", want.mid, out_bytes_mid);
                    check_field("out_bytes_high", want.high, out_bytes_high);
                    check_field("out_count", 64'(want.count), 64'(out_count));
                    check_field("out_last", 64'(want.last), 64'(out_last));
                end
            end
            if (start && !busy)
                pending_escapes.push_back(escape_chunk(in_bytes, in_count, in_last));
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:REG_IDX_LSB])
                    REG_SET_BITS_0: charset[63:0]    = pwdata;
                    REG_SET_BITS_1: charset[127:64]  = pwdata;
                    REG_SET_BITS_2: charset[191:128] = pwdata;
                    REG_SET_BITS_3: charset[255:192] = pwdata;
                    default: ;
                endcase
            end
            outstanding <= pending_escapes.size();
        end
    end

endmodule

@@ verif/percent_encoder_bitmap_set_tb.sv @@
// Testbench top for the percent encoder: drives requests and charset writes, reports the verdict.
module percent_encoder_bitmap_set_tb;
    import pebs_pkg::*;

    // The worst case has every request followed by the longest gap;
    // allow several times that before calling it a hang.
    localparam int TIMEOUT       = 2_000_000;
    // Pipeline is two stages deep; wait a bit longer for stray results.
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 140;
    localparam int MAX_COUNT     = (1 << IN_CNT_W) - 1;

    // Charset for URL components: controls, space, quote, hash, angle brackets,
    // backquote, braces, DEL and every byte from 0x80 up.
    localparam logic [63:0] URL_SET_0 = 64'h5000_000D_FFFF_FFFF;
    localparam logic [63:0] URL_SET_1 = 64'hA800_0001_0000_0000;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 start    = 1'b0;
    logic [63:0]          in_bytes = '0;
    logic [IN_CNT_W-1:0]  in_count = '0;
    logic                 in_last  = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_W-1:0]    paddr    = '0;
    logic [DATA_W-1:0]    pwdata   = '0;
    logic                 busy;
    logic                 done;
    logic [63:0]          out_bytes_low;
    logic [63:0]          out_bytes_mid;
    logic [63:0]          out_bytes_high;
    logic [OUT_CNT_W-1:0] out_count;
    logic                 out_last;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    int mismatch_count;
    int outstanding;
    // When set, requests go back to back with no idle cycles at all.
    bit burst_phase = 1'b0;

    percent_encoder_bitmap_set dut (.*);

    percent_escape_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hang guard: a lost result or a stuck busy ends here.
    initial
    begin
        #TIMEOUT;
        $display("TB_ERROR");
        $finish;
    end

    // One APB write: setup cycle, then access until pready; drop the bus
    // afterwards so back-to-back writes never touch psel twice in a step.
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << REG_IDX_LSB;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_charset(input logic [63:0] w0, input logic [63:0] w1,
                                   input logic [63:0] w2, input logic [63:0] w3);
        apb_write(REG_SET_BITS_0, w0);
        apb_write(REG_SET_BITS_1, w1);
        apb_write(REG_SET_BITS_2, w2);
        apb_write(REG_SET_BITS_3, w3);
    endtask

    // Present one request and hold it until the block takes it, then maybe idle.
    // Start stays high into the next request when no gap is drawn.
    task automatic send_request(input logic [63:0] bytes, input logic [IN_CNT_W-1:0] cnt,
                                input logic lst);
        int gap;
        int pick;
        start    <= 1'b1;
        in_bytes <= bytes;
        in_count <= cnt;
        in_last  <= lst;
        do @(posedge clk); while (busy);
        // Mostly no gap or a short one, now and then a long one.
        pick = $urandom_range(0, 99);
        if (burst_phase || pick < 55)
            gap = 0;
        else if (pick < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(4, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random request: mostly legal counts, a few zero or excess counts;
    // half the time the bytes are printable text, else any byte at all.
    task automatic send_random_request();
        logic [63:0]         bytes;
        logic [IN_CNT_W-1:0] cnt;
        int                  pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            cnt = '0;
        else if (pick == 1)
            cnt = IN_CNT_W'($urandom_range(LANES + 1, MAX_COUNT));
        else
            cnt = IN_CNT_W'($urandom_range(1, LANES));
        if ($urandom_range(0, 1) == 1)
            bytes = {$urandom, $urandom};
        else
            for (int k = 0; k < 8; k++)
                bytes[8*k +: 8] = 8'($urandom_range(8'h20, 8'h7E));
        send_request(bytes, cnt, 1'($urandom_range(0, 3) == 0));
    endtask

    // Drop start and hold until every request has come back, then let the
    // pipeline run empty so no result is in flight during a charset write.
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] random_charset_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return {$urandom, $urandom} & {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Charset still cleared by reset: every byte passes through.
        send_request(64'h0000_0000_0000_0000, 4'd8, 1'b0);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
        // Zero count: empty result, last still copied.
        send_request(64'h0706_0504_0302_0100, 4'd0, 1'b1);
        // Excess count saturates to the lane count.
        send_request(64'h6867_6665_6463_6261, 4'd15, 1'b0);
        settle();

        // Everything marked: eight bytes expand to the full 24-byte result.
        program_charset('1, '1, '1, '1);
        send_request(64'h0123_4567_89AB_CDEF, 4'd8, 1'b0);
        send_request(64'hFEDC_BA98_7654_3210, 4'd8, 1'b1);
        // Bytes beyond the count are ignored.
        send_request(64'hFFFF_FFFF_FFFF_FF0A, 4'd1, 1'b0);
        send_request(64'hA5A5_A5A5_A5A5_A5A5, 4'd0, 1'b0);
        send_request(64'h5A5A_5A5A_5A5A_5A5A, 4'd9, 1'b1);
        settle();

        // A realistic URL set: mixes of escaped and plain bytes.
        program_charset(URL_SET_0, URL_SET_1, '1, '1);
        send_request(64'h653E_3C64_6320_6261, 4'd8, 1'b0);   // "ab cd<>e"
        send_request(64'h7F7E_7D7B_6025_2322, 4'd8, 1'b0);
        send_request(64'h80FF_1F00_417A_3039, 4'd8, 1'b1);
        send_request(64'h2020_2020_2F2F_3A70, 4'd3, 1'b1);
        send_request(64'h3F3D_2641_2E2D_5F7E, 4'd8, 1'b0);
        send_request(64'hC3A9_E282_AC20_7A20, 4'd7, 1'b1);
        settle();

        // Alternating bitmap: odd byte values marked in words 0 and 2, even ones in words 1 and 3.
        program_charset({32{2'b10}}, {32{2'b01}}, {32{2'b10}}, {32{2'b01}});
        repeat (100) send_random_request();
        settle();

        // Random charsets, some phases with no idle cycles at all.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            program_charset(random_charset_word(), random_charset_word(),
                            random_charset_word(), random_charset_word());
            burst_phase = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) send_random_request();
            settle();
        end

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
